### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for concurrent checks, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/srpwm_pkg.sv
// ----------------------------------------------------------------------------
// srpwm_pkg
// Types and constants shared by the shift-register PWM LED driver.
// ----------------------------------------------------------------------------
package srpwm_pkg;

	// request kinds carried in s_tuser
	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_LEVEL = 2'd1,
		KIND_BAR   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SHIFT
	} state_t;

	localparam int DUTY_W  = 8;
	localparam int BAR_W   = 5;
	localparam int CHAN_W  = 4;
	localparam int LVL_W   = 9;
	localparam int IDX_W   = 8;
	// divider operand widths: index*255 and the level count
	localparam int NUM_W   = 16;
	localparam int DEN_W   = 9;
	// wide enough for any channel number or count up to 64
	localparam int CNT_W   = 7;

	localparam logic [LVL_W-1:0] LEVELS_RST = 9'd64;
	localparam logic [LVL_W-1:0] LEVELS_MAX = 9'd256;

	// register byte addresses
	localparam logic [2:0] ADDR_LEVELS = 3'd0;

	// control broadcast to every cell of the chain
	typedef struct packed {
		logic              capture;
		logic              shift;
		logic              use_bar;
		logic              from_bottom;
		logic [BAR_W-1:0]  bar;
		logic [NUM_W-1:0]  thr;
	} ctl_t;

endpackage

### rtl/shift_register_pwm_led_driver_top.sv
// ----------------------------------------------------------------------------
// shift_register_pwm_led_driver_top
// Multi-channel LED dimmer feeding a serial shift-register chain.
// ----------------------------------------------------------------------------
// A load request stores one channel's duty and leaves the block idle. A
// level-step request divides level_index*255 by the level count in a
// bit-serial divider, then shifts CHANNELS bits out, highest channel first,
// with tlast on channel 0. A bar request skips the divider and shifts its
// frame out directly. The frame is held in a row of per-channel cells that
// shift one place per accepted output, so one request is handled at a time.
module shift_register_pwm_led_driver_top
	import srpwm_pkg::*;
#(
	parameter int CHANNELS = 16
)
(
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // channel[3:0], duty[11:4], bar_count[16:12],
	                              // from_bottom[17], zero[23:18]
	input  logic [1:0]  s_tuser,  // kind[1:0]
	// bit stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // serial_bit[0], bit_channel[4:1], zero[7:5]
	output logic        m_tlast,  // latch
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	`include "assert_macros.svh"

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

	state_t            state_q, state_d;
	logic [LVL_W-1:0]  levels_q;
	logic [IDX_W-1:0]  level_idx_q;
	logic [CH_W-1:0]   ch_q;

	kind_t             in_kind;
	logic [CHAN_W-1:0] in_channel;
	logic [DUTY_W-1:0] in_duty;
	logic [BAR_W-1:0]  in_bar;
	logic              in_from_bottom;
	logic              in_acc;
	logic              out_acc;
	logic              load_acc;

	logic [DEN_W-1:0]  eff_levels;
	logic [NUM_W-1:0]  thr_num;
	logic [NUM_W-1:0]  mod_num;
	logic              div_start;
	logic              thr_busy, thr_done, mod_busy, mod_done;
	logic [NUM_W-1:0]  thr_quo, mod_quo;
	logic [DEN_W-1:0]  thr_rem, mod_rem;

	ctl_t              ctl;
	logic [CHANNELS:0] links;
	logic [CH_W+3:0]   ch_ext;

	assign in_kind        = kind_t'(s_tuser);
	assign in_channel     = s_tdata[3:0];
	assign in_duty        = s_tdata[11:4];
	assign in_bar         = s_tdata[16:12];
	assign in_from_bottom = s_tdata[17];

	assign in_acc   = s_tvalid && s_tready;
	assign out_acc  = m_tvalid && m_tready;
	assign load_acc = in_acc && (in_kind == KIND_LOAD);

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q <= LEVELS_RST;
		end else if (psel && penable && pwrite && pready && paddr[2] == ADDR_LEVELS[2]) begin
			levels_q <= pwdata[LVL_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == ADDR_LEVELS[2]) begin
			prdata = {{(32-LVL_W){1'b0}}, levels_q};
		end
	end

	// clamp the level count to 1..256
	always_comb begin
		priority if (levels_q == '0) begin
			eff_levels = DEN_W'(1);
		end else if (levels_q > LEVELS_MAX) begin
			eff_levels = LEVELS_MAX;
		end else begin
			eff_levels = levels_q;
		end
		// index*255 as index*256 - index
		thr_num = {level_idx_q, 8'd0} - {8'd0, level_idx_q};
		mod_num = {8'd0, level_idx_q} + NUM_W'(1);
	end

	srpwm_div u_thr_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (thr_num),
		.den    (eff_levels),
		.busy   (thr_busy),
		.done   (thr_done),
		.quo    (thr_quo),
		.rem    (thr_rem)
	);

	srpwm_div u_mod_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mod_num),
		.den    (eff_levels),
		.busy   (mod_busy),
		.done   (mod_done),
		.quo    (mod_quo),
		.rem    (mod_rem)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (in_kind)
						KIND_LEVEL: state_d = ST_DIV;
						KIND_BAR:   state_d = ST_SHIFT;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_DIV: begin
				if (thr_done) begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				if (out_acc && ch_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready        = (state_q == ST_IDLE);
		m_tvalid        = (state_q == ST_SHIFT);
		div_start       = in_acc && (in_kind == KIND_LEVEL);
		ctl.capture     = 1'b0;
		ctl.use_bar     = 1'b0;
		ctl.shift       = out_acc;
		ctl.from_bottom = in_from_bottom;
		ctl.bar         = in_bar;
		ctl.thr         = thr_quo;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && in_kind == KIND_BAR) begin
					ctl.capture = 1'b1;
					ctl.use_bar = 1'b1;
				end
			end
			ST_DIV: begin
				ctl.capture = thr_done;
			end
			default: begin
				ctl.capture = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			level_idx_q <= '0;
			ch_q        <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.capture) begin
				ch_q <= CH_LAST;
			end else if (out_acc) begin
				ch_q <= ch_q - 1'b1;
			end
			// remainder is below the level count, so it fits the index
			if (state_q == ST_DIV && mod_done) begin
				level_idx_q <= mod_rem[IDX_W-1:0];
			end
		end
	end

	// channel cells; bits move toward the top cell, which drives the output
	assign links[0] = 1'b0;

	for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
		srpwm_cell #(
			.IDX      (g),
			.CHANNELS (CHANNELS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.wr_en    (load_acc && ({{(CNT_W-CHAN_W){1'b0}}, in_channel} == CNT_W'(g))),
			.wr_duty  (in_duty),
			.shift_in (links[g]),
			.bit_out  (links[g+1])
		);
	end

	assign ch_ext   = {4'd0, ch_q};
	assign m_tdata  = {3'd0, ch_ext[3:0], links[CHANNELS]};
	assign m_tlast  = (ch_q == '0);

	`ASSERT_ALWAYS(a_one_side_open, !(s_tready && m_tvalid), "input and output open together")
	`ASSERT_NEXT(a_frame_closes, out_acc && m_tlast, !m_tvalid, "frame continues after latch bit")
	`ASSERT_IMPLIES(a_div_in_step, thr_done, mod_done && !thr_busy && !mod_busy,
		"threshold and index dividers out of step")
	`ASSERT_NEXT(a_div_to_frame, state_q == ST_DIV && thr_done, m_tvalid && ch_q == CH_LAST,
		"frame does not start at the top channel")
	`ASSERT_IMPLIES(a_div_ranges, thr_done,
		thr_rem < eff_levels && mod_quo <= NUM_W'(LEVELS_MAX),
		"divider result out of range")

endmodule

### rtl/srpwm_div.sv
// ----------------------------------------------------------------------------
// srpwm_div
// Restoring divider, one quotient bit per cycle, with remainder.
// ----------------------------------------------------------------------------
module srpwm_div
	import srpwm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W-1:0] rem
);

	localparam int CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;
	logic [DEN_W:0]   diff;

	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		fits  = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the top bit drops
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = num_q;
	assign rem  = rem_q;

endmodule

### rtl/srpwm_cell.sv
// ----------------------------------------------------------------------------
// srpwm_cell
// One channel: holds its duty, decides its bit and passes it up the chain.
// ----------------------------------------------------------------------------
module srpwm_cell
	import srpwm_pkg::*;
#(
	parameter int IDX      = 0,
	parameter int CHANNELS = 16
)
(
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_t              ctl,
	input  logic              wr_en,
	input  logic [DUTY_W-1:0] wr_duty,
	input  logic              shift_in,
	output logic              bit_out
);

	localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);
	localparam logic [CNT_W-1:0] REM_C = CNT_W'(CHANNELS - IDX);

	logic [DUTY_W-1:0] duty_q;
	logic              bit_q;
	logic [CNT_W-1:0]  bar_ext;
	logic              lit_bar;
	logic              lit_pwm;

	always_comb begin
		bar_ext = {{(CNT_W-BAR_W){1'b0}}, ctl.bar};
		lit_bar = ctl.from_bottom ? (bar_ext > IDX_C) : (REM_C <= bar_ext);
		lit_pwm = {{(NUM_W-DUTY_W){1'b0}}, duty_q} > ctl.thr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q <= '0;
			bit_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				duty_q <= wr_duty;
			end
			if (ctl.capture) begin
				bit_q <= ctl.use_bar ? lit_bar : lit_pwm;
			end else if (ctl.shift) begin
				bit_q <= shift_in;
			end
		end
	end

	assign bit_out = bit_q;

endmodule

### tb/shift_register_pwm_led_driver_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shift_register_pwm_led_driver_top_tb
// Self-checking bench for the shift-register PWM LED driver.
// ----------------------------------------------------------------------------
// Drives duty loads, PWM level steps and bar patterns through the request
// stream. Idle gaps are random on both streams. The level count is rewritten
// between phases, including zero and values above the top of its range. A
// scoreboard predicts every shifted frame and checks each accepted bit in order.
// ----------------------------------------------------------------------------
import srpwm_pkg::*;

class bit_frame_scoreboard #(int NCH = 16);
	typedef struct packed {
		logic              serial;
		logic [CHAN_W-1:0] chan;
		logic              latch;
	} shift_bit_t;

	logic [LVL_W-1:0]  levels;
	logic [DUTY_W-1:0] duty_mem [NCH];
	int unsigned       level_idx;
	shift_bit_t        pending_bits [$];
	int                errors;

	function new();
		levels = LEVELS_RST;
		foreach (duty_mem[i]) duty_mem[i] = '0;
		level_idx = 0;
		errors = 0;
	endfunction

	// zero acts as one level, anything above the maximum as the maximum
	function int unsigned active_levels();
		if (levels == 0) return 1;
		if (levels > LEVELS_MAX) return LEVELS_MAX;
		return levels;
	endfunction

	function void note_request(logic [1:0] kind, logic [CHAN_W-1:0] chan,
			logic [DUTY_W-1:0] duty, logic [BAR_W-1:0] bar, logic from_bottom);
		logic        lit [NCH];
		int unsigned lv;
		int unsigned thr;
		shift_bit_t  b;
		case (kind)
		KIND_LOAD: begin
			if (chan < NCH) duty_mem[chan] = duty;
			return;
		end
		KIND_LEVEL: begin
			lv = active_levels();
			// the index may sit above a freshly lowered level count: use it as is
			thr = ((level_idx & 8'hff) * 255) / lv;
			for (int i = 0; i < NCH; i++) lit[i] = duty_mem[i] > thr;
			level_idx = (((level_idx & 8'hff) + 1) % lv) & 8'hff;
		end
		KIND_BAR: begin
			for (int i = 0; i < NCH; i++)
				lit[i] = from_bottom ? (i < bar) : ((NCH - i) <= bar);
		end
		default: return;
		endcase
		for (int ch = NCH - 1; ch >= 0; ch--) begin
			b.serial = lit[ch];
			b.chan   = ch[CHAN_W-1:0];
			b.latch  = (ch == 0);
			pending_bits.push_back(b);
		end
	endfunction

	function void check_bit(logic serial, logic [CHAN_W-1:0] chan, logic latch);
		shift_bit_t want;
		if (pending_bits.size() == 0) begin
			$error("bit with no frame pending: serial_bit %0d bit_channel %0d latch %0d",
				serial, chan, latch);
			errors++;
			return;
		end
		want = pending_bits.pop_front();
		if (want.serial !== serial) begin
			$error("serial_bit: expected %0d, actual %0d", want.serial, serial);
			errors++;
		end
		if (want.chan !== chan) begin
			$error("bit_channel: expected %0d, actual %0d", want.chan, chan);
			errors++;
		end
		if (want.latch !== latch) begin
			$error("latch: expected %0d, actual %0d", want.latch, latch);
			errors++;
		end
	endfunction
endclass

module shift_register_pwm_led_driver_top_tb;
	localparam int N_CHAN      = 16;
	localparam int TAIL_CYCLES = 40;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 26;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	bit_frame_scoreboard #(N_CHAN) board;
	int unsigned cycles = 0;
	bit          calm = 1'b0;

	shift_register_pwm_led_driver_top #(.CHANNELS(N_CHAN)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_bit(m_tdata[0], m_tdata[4:1], m_tlast);
	end

	// mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	initial begin
		int unsigned gap;
		m_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = pick_gap();
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	task automatic send_request(logic [1:0] kind, logic [3:0] chan, logic [7:0] duty,
			logic [4:0] bar, logic from_bottom);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, from_bottom, bar, duty, chan};
		s_tuser  <= kind;
		do @(posedge clk); while (!s_tready);
		board.note_request(kind, chan, duty, bar, from_bottom);
	endtask

	// drop valid, wait out every pending bit, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending_bits.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic set_levels(logic [LVL_W-1:0] value);
		drain();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_LEVELS;
		pwdata  <= {{(32-LVL_W){1'b0}}, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		board.levels = value;
	endtask

	// returns 1 when the request is one the block acts on
	task automatic send_random(output bit counted);
		int unsigned r;
		logic [1:0]  kind;
		logic [7:0]  duty;
		logic [4:0]  bar;
		r = $urandom_range(0, 99);
		if (r < 40) kind = KIND_LOAD;
		else if (r < 80) kind = KIND_LEVEL;
		else if (r < 95) kind = KIND_BAR;
		else kind = KIND_UNUSED;
		r = $urandom_range(0, 9);
		if (r == 0) duty = 8'd0;
		else if (r == 1) duty = 8'hff;
		else duty = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 9) < 6) bar = 5'($urandom_range(0, N_CHAN));
		else bar = 5'($urandom_range(0, 31));
		send_request(kind, 4'($urandom_range(0, 15)), duty, bar, 1'($urandom_range(0, 1)));
		counted = (kind != KIND_UNUSED);
	endtask

	initial begin
		logic [LVL_W-1:0] phase_levels [PHASES];
		int               done;
		bit               counted;
		board = new();
		arst_n   = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bar extremes, including counts past the channel count
		send_request(KIND_BAR, 4'd0, 8'd0, 5'd0, 1'b1);
		send_request(KIND_BAR, 4'd15, 8'hff, 5'd16, 1'b1);
		send_request(KIND_BAR, 4'd5, 8'h5a, 5'd5, 1'b0);
		send_request(KIND_BAR, 4'd0, 8'd0, 5'd31, 1'b0);
		send_request(KIND_BAR, 4'd9, 8'ha5, 5'd17, 1'b1);
		// level step with an empty duty store
		send_request(KIND_LEVEL, 4'd0, 8'd0, 5'd0, 1'b0);
		send_request(KIND_LOAD, 4'd0, 8'hff, 5'd0, 1'b0);
		send_request(KIND_LOAD, 4'd15, 8'd1, 5'd31, 1'b1);
		send_request(KIND_LOAD, 4'd7, 8'd128, 5'd0, 1'b0);
		send_request(KIND_LOAD, 4'd8, 8'd0, 5'd16, 1'b1);
		send_request(KIND_LOAD, 4'd3, 8'd254, 5'd0, 1'b0);
		// unused kind leaves everything alone
		send_request(KIND_UNUSED, 4'd15, 8'hff, 5'd31, 1'b1);
		repeat (3) send_request(KIND_LEVEL, 4'd0, 8'd0, 5'd0, 1'b0);
		set_levels(9'd1);
		repeat (2) send_request(KIND_LEVEL, 4'd0, 8'd0, 5'd0, 1'b0);
		set_levels(LEVELS_MAX);
		repeat (2) send_request(KIND_LEVEL, 4'd0, 8'd0, 5'd0, 1'b0);
		set_levels(9'd0);
		send_request(KIND_LEVEL, 4'd0, 8'd0, 5'd0, 1'b0);
		set_levels(9'd511);
		send_request(KIND_LEVEL, 4'd0, 8'd0, 5'd0, 1'b0);

		// a long phase at the top count followed by a tiny count leaves the
		// index above the new level count
		phase_levels = '{9'd256, 9'd3, 9'd511, 9'd0, 9'd100, 9'd2, 9'd1, 9'd64};
		phase_levels[4] = 9'($urandom_range(4, 255));
		for (int p = 0; p < PHASES; p++) begin
			set_levels(phase_levels[p]);
			calm = (p == 5);
			done = 0;
			while (done < PHASE_ITEMS) begin
				send_random(counted);
				if (counted) done++;
			end
		end
		calm = 1'b0;
		drain();

		if (board.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

### shift_register_pwm_led_driver_top.f
+incdir+rtl
rtl/srpwm_pkg.sv
rtl/srpwm_div.sv
rtl/srpwm_cell.sv
rtl/shift_register_pwm_led_driver_top.sv
tb/shift_register_pwm_led_driver_top_tb.sv
